// ----- sv/camp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package camp_pkg;
   localparam int TabLen = 24;
   localparam int AccW = 36;
   localparam int PhW = 33;
   localparam logic [31:0] ARC_TAB [TabLen] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };
   localparam logic [15:0] GAIN_Q16 = 16'd39797;
   localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
   localparam logic signed [23:0] MIN24 = -24'sh800000;

   typedef struct packed {
      logic signed [AccW-1:0] x;
      logic signed [AccW-1:0] y;
      logic signed [PhW-1:0]  z;
      logic                   flip;
   } rot_type;

   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      logic signed [23:0] r;
      begin
         if (v > 28'(MAX24)) r = MAX24;
         else if (v < 28'(MIN24)) r = MIN24;
         else r = v[23:0];
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// ----- sv/circular_arc_move_point.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Turning circle centre and arc end point. Each request carries a position,
// a heading, a radius and a signed turn angle; the response gives the circle
// centre (left of the heading for counterclockwise turns, right for clockwise)
// and the point reached along the arc, each saturated to 24 bits. The block
// is a pipeline that accepts one request every cycle while it is not stalled.
// It is built from one input stage that folds the angles and scales the
// radius, one register per CORDIC rotation in two parallel units (heading and
// heading plus turn), and one output stage that rounds the rotated vectors,
// sums and saturates. A stall freezes the whole pipeline in place.
module circular_arc_move_point import camp_pkg::*; #(
   parameter int ROTATION_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic [15:0] req_heading,
   input  wire logic [15:0] req_turn_radius,
   input  wire logic signed [15:0] req_turn_angle,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [23:0] rsp_center_x,
   output logic signed [23:0] rsp_center_y,
   output logic signed [23:0] rsp_end_x,
   output logic signed [23:0] rsp_end_y
);
   // The position and direction travel beside the CORDIC stages: the input
   // stage plus one register per rotation.
   localparam int Depth = ROTATION_STEPS + 1;

   // The pipeline moves whenever the output slot is free or being taken.
   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic [Depth-1:0] vld_ff;
   logic signed [23:0] px_ff [Depth];
   logic signed [23:0] py_ff [Depth];
   logic ccw_ff [Depth];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff[0] <= req_pos_x;
         py_ff[0] <= req_pos_y;
         ccw_ff[0] <= !req_turn_angle[15];
         for (int i = 1; i < Depth; i++) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
            ccw_ff[i] <= ccw_ff[i-1];
         end
      end
   end

   logic [15:0] end_ang;
   assign end_ang = req_heading + req_turn_angle;

   logic signed [20:0] rc, rs, ec, es;
   camp_cordic #(.ROTATION_STEPS(ROTATION_STEPS)) u_head (
      .clock(clock), .reset(reset), .adv(adv), .radius(req_turn_radius),
      .angle(req_heading), .rcos(rc), .rsin(rs)
   );
   camp_cordic #(.ROTATION_STEPS(ROTATION_STEPS)) u_end (
      .clock(clock), .reset(reset), .adv(adv), .radius(req_turn_radius),
      .angle(end_ang), .rcos(ec), .rsin(es)
   );

   // Final stage: centre and end point from the unsaturated centre.
   logic signed [27:0] cx, cy, ex, ey;
   logic signed [23:0] pxl, pyl;
   assign pxl = px_ff[Depth-1];
   assign pyl = py_ff[Depth-1];
   always_comb begin
      if (ccw_ff[Depth-1]) begin
         cx = 28'(pxl) - 28'(rs);
         cy = 28'(pyl) + 28'(rc);
         ex = cx + 28'(es);
         ey = cy - 28'(ec);
      end else begin
         cx = 28'(pxl) + 28'(rs);
         cy = 28'(pyl) - 28'(rc);
         ex = cx - 28'(es);
         ey = cy + 28'(ec);
      end
   end

   logic rsp_valid_ff;
   logic signed [23:0] cx_ff, cy_ff, ex_ff, ey_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vld_ff[Depth-1];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff <= sat24(cx);
         cy_ff <= sat24(cy);
         ex_ff <= sat24(ex);
         ey_ff <= sat24(ey);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_center_x = cx_ff;
   assign rsp_center_y = cy_ff;
   assign rsp_end_x = ex_ff;
   assign rsp_end_y = ey_ff;
endmodule
`default_nettype wire

// ----- sv/camp_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module camp_cordic import camp_pkg::*; #(
   parameter int ROTATION_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        adv,
   input  wire logic [15:0] radius,
   input  wire logic [15:0] angle,
   output logic signed [20:0] rcos,
   output logic signed [20:0] rsin
);
   // Stage 0 folds the angle and scales the radius; one stage per rotation after it.
   rot_type st_ff [ROTATION_STEPS+1];
   rot_type st_in [ROTATION_STEPS+1];
   logic [31:0] ph;
   logic [31:0] phf;
   logic flip0;
   logic signed [AccW-1:0] xo, yo, xr, yr;

   always_comb begin
      ph = {angle, 16'd0};
      flip0 = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
      phf = flip0 ? ph + 32'h80000000 : ph;
      st_in[0].x = AccW'($signed({1'b0, 32'(radius) * 32'(GAIN_Q16)}));
      st_in[0].y = '0;
      st_in[0].z = PhW'($signed(phf));
      st_in[0].flip = flip0;
   end

   for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_stage
      always_comb begin
         st_in[i+1] = st_ff[i];
         if (!st_ff[i].z[PhW-1]) begin
            st_in[i+1].x = st_ff[i].x - (st_ff[i].y >>> i);
            st_in[i+1].y = st_ff[i].y + (st_ff[i].x >>> i);
            st_in[i+1].z = st_ff[i].z - PhW'(ARC_TAB[i]);
         end else begin
            st_in[i+1].x = st_ff[i].x + (st_ff[i].y >>> i);
            st_in[i+1].y = st_ff[i].y - (st_ff[i].x >>> i);
            st_in[i+1].z = st_ff[i].z + PhW'(ARC_TAB[i]);
         end
      end
   end

   for (genvar i = 0; i <= ROTATION_STEPS; i++) begin : g_reg
      always_ff @(posedge clock) begin
         if (adv) st_ff[i] <= st_in[i];
      end
   end

   always_comb begin
      xo = st_ff[ROTATION_STEPS].flip ? -st_ff[ROTATION_STEPS].x : st_ff[ROTATION_STEPS].x;
      yo = st_ff[ROTATION_STEPS].flip ? -st_ff[ROTATION_STEPS].y : st_ff[ROTATION_STEPS].y;
      xr = (xo + AccW'(32768)) >>> 16;
      yr = (yo + AccW'(32768)) >>> 16;
      rcos = xr[20:0];
      rsin = yr[20:0];
   end

   logic unused_reset;
   assign unused_reset = reset;
endmodule
`default_nettype wire

// ----- sv/camp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module camp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic signed [23:0] rsp_center_x,
   input wire logic signed [23:0] rsp_end_x
);
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall)) else $error("input stalled needlessly");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_center_x)
      && $stable(rsp_end_x))) else $error("response changed under stall");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("response valid after reset");
   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall) else $error("stall with empty output");
   logic unused;
   assign unused = req_valid;
endmodule

bind circular_arc_move_point camp_checker u_camp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_center_x(rsp_center_x), .rsp_end_x(rsp_end_x)
);
`default_nettype wire
